[src/acb_pkg.sv]
// Shared types and constants for the accumulator bytecode CPU unit.
package acb_pkg;

   localparam int STACK_DEPTH_DEF = 32;
   localparam int MEM_DEPTH       = 256;

   localparam logic [7:0] OP_LOAD_IMM = 8'h01;
   localparam logic [7:0] OP_ADD      = 8'h02;
   localparam logic [7:0] OP_PRINT    = 8'h03;
   localparam logic [7:0] OP_CMP      = 8'h04;
   localparam logic [7:0] OP_JEQ      = 8'h05;
   localparam logic [7:0] OP_JMP      = 8'h06;
   localparam logic [7:0] OP_PUSH     = 8'h07;
   localparam logic [7:0] OP_POP      = 8'h08;
   localparam logic [7:0] OP_XOR      = 8'h09;
   localparam logic [7:0] OP_STORE    = 8'h0A;
   localparam logic [7:0] OP_LOAD     = 8'h0B;
   localparam logic [7:0] OP_SYSCALL  = 8'h0C;
   localparam logic [7:0] OP_HALT     = 8'hFF;

   localparam logic [2:0] ST_NORMAL  = 3'd0;
   localparam logic [2:0] ST_PRINT   = 3'd1;
   localparam logic [2:0] ST_SYSCALL = 3'd2;
   localparam logic [2:0] ST_HALT    = 3'd3;
   localparam logic [2:0] ST_INVALID = 3'd4;
   localparam logic [2:0] ST_STOPPED = 3'd5;

   typedef struct packed {
      logic [7:0] opcode;
      logic [7:0] operand;
   } req_type;

   typedef struct packed {
      logic [7:0] next_pc;
      logic [7:0] acc_value;
      logic [2:0] status;
      logic [7:0] syscall_id;
   } rsp_type;

endpackage

[src/accumulator_bytecode_cpu_unit.sv]
// Accumulator bytecode CPU: executes one instruction per request.
//
// Usage: each request on req_* carries an opcode and the program byte that
// follows it. Every request yields exactly one response on rsp_* with the
// next program counter, the accumulator, a status code and a syscall id.
// The request is accepted when req_valid is high and req_stall is low; the
// response is taken when rsp_valid is high and rsp_stall is low.
// A request passes through an input register, during which the data memory is
// read at the operand address, then executes into the response register.
// Throughput is one request per cycle unless a response is held by rsp_stall;
// the accumulator, flag, stack pointer and program counter update in the execute stage.
// When rsp_stall is high with a response held, the execute stage holds and
// req_stall rises once the input register is full.
// Reset clears pc, accumulator, flag, stack pointer and the stopped state;
// data memory reads as zero until written, through per-byte valid bits
// cleared at reset, so no clearing pass is needed. After halt or an invalid
// opcode every response reports the held state with status already stopped.
module accumulator_bytecode_cpu_unit #(
   parameter int STACK_DEPTH = acb_pkg::STACK_DEPTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  acb_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output acb_pkg::rsp_type rsp_data
);

   localparam int SP_W  = $clog2(STACK_DEPTH + 1);
   localparam int IDX_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

   // pipeline control
   logic             in_valid_ff, in_valid_in;
   acb_pkg::req_type in_data_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   acb_pkg::rsp_type rsp_data_ff, rsp_data_in;
   logic             advance, exec_go, req_fire;

   // architectural state
   logic [7:0]      pc_ff, pc_in;
   logic [7:0]      acc_ff, acc_in;
   logic            flag_ff, flag_in;
   logic [SP_W-1:0] sp_ff, sp_in;
   logic            stopped_ff, stopped_in;

   // storage
   logic [7:0] stack_mem [STACK_DEPTH];
   logic [7:0] data_mem [acb_pkg::MEM_DEPTH];
   logic [acb_pkg::MEM_DEPTH-1:0] mem_valid_ff;
   logic [7:0] rd_data_ff;
   logic       rd_valid_ff;

   logic            do_push, do_pop, do_store;
   logic [SP_W-1:0] sp_dec;
   logic [7:0]      pc1, pc2, ld_data, pop_data;

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign exec_go   = in_valid_ff && advance;
   assign req_stall = in_valid_ff && !advance;
   assign req_fire  = req_valid && !req_stall;

   assign in_valid_in  = req_fire ? 1'b1 : (exec_go ? 1'b0 : in_valid_ff);
   assign rsp_valid_in = exec_go ? 1'b1 : (rsp_stall ? rsp_valid_ff : 1'b0);

   assign pc1      = pc_ff + 8'd1;
   assign pc2      = pc_ff + 8'd2;
   assign sp_dec   = sp_ff - SP_W'(1);
   assign pop_data = stack_mem[sp_dec[IDX_W-1:0]];
   assign ld_data  = rd_valid_ff ? rd_data_ff : 8'd0;

   always_comb begin
      pc_in       = pc_ff;
      acc_in      = acc_ff;
      flag_in     = flag_ff;
      sp_in       = sp_ff;
      stopped_in  = stopped_ff;
      do_push     = 1'b0;
      do_pop      = 1'b0;
      do_store    = 1'b0;
      rsp_data_in = '{next_pc: pc_ff, acc_value: acc_ff,
                      status: acb_pkg::ST_STOPPED, syscall_id: 8'd0};
      if (!stopped_ff) begin
         pc_in = pc2;
         rsp_data_in.status = acb_pkg::ST_NORMAL;
         unique case (in_data_ff.opcode)
            acb_pkg::OP_LOAD_IMM: acc_in = in_data_ff.operand;
            acb_pkg::OP_ADD:      acc_in = acc_ff + in_data_ff.operand;
            acb_pkg::OP_PRINT: begin
               pc_in = pc1;
               rsp_data_in.status = acb_pkg::ST_PRINT;
            end
            acb_pkg::OP_CMP:      flag_in = (acc_ff == in_data_ff.operand);
            acb_pkg::OP_JEQ: begin
               if (flag_ff) pc_in = in_data_ff.operand;
            end
            acb_pkg::OP_JMP:      pc_in = in_data_ff.operand;
            acb_pkg::OP_PUSH: begin
               pc_in = pc1;
               if (sp_ff < SP_W'(STACK_DEPTH)) begin
                  do_push = 1'b1;
                  sp_in   = sp_ff + SP_W'(1);
               end
            end
            acb_pkg::OP_POP: begin
               pc_in = pc1;
               if (sp_ff != '0) begin
                  do_pop = 1'b1;
                  sp_in  = sp_dec;
                  acc_in = pop_data;
               end
            end
            acb_pkg::OP_XOR:      acc_in = acc_ff ^ in_data_ff.operand;
            acb_pkg::OP_STORE:    do_store = 1'b1;
            acb_pkg::OP_LOAD:     acc_in = ld_data;
            acb_pkg::OP_SYSCALL: begin
               rsp_data_in.status     = acb_pkg::ST_SYSCALL;
               rsp_data_in.syscall_id = in_data_ff.operand;
            end
            acb_pkg::OP_HALT: begin
               pc_in = pc1;
               stopped_in = 1'b1;
               rsp_data_in.status = acb_pkg::ST_HALT;
            end
            default: begin
               pc_in = pc1;
               stopped_in = 1'b1;
               rsp_data_in.status = acb_pkg::ST_INVALID;
            end
         endcase
         rsp_data_in.next_pc   = pc_in;
         rsp_data_in.acc_value = acc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         pc_ff        <= 8'd0;
         acc_ff       <= 8'd0;
         flag_ff      <= 1'b0;
         sp_ff        <= '0;
         stopped_ff   <= 1'b0;
         mem_valid_ff <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (exec_go) begin
            pc_ff      <= pc_in;
            acc_ff     <= acc_in;
            flag_ff    <= flag_in;
            sp_ff      <= sp_in;
            stopped_ff <= stopped_in;
            if (do_store) mem_valid_ff[in_data_ff.operand] <= 1'b1;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_fire) in_data_ff <= req_data;
      if (exec_go)  rsp_data_ff <= rsp_data_in;
   end

   // data memory: read at accept, bypass a store retiring on the same edge
   always_ff @(posedge clock) begin
      if (exec_go && do_store) data_mem[in_data_ff.operand] <= acc_ff;
      if (req_fire) begin
         if (exec_go && do_store && in_data_ff.operand == req_data.operand) begin
            rd_data_ff  <= acc_ff;
            rd_valid_ff <= 1'b1;
         end else begin
            rd_data_ff  <= data_mem[req_data.operand];
            rd_valid_ff <= mem_valid_ff[req_data.operand];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (exec_go && do_push) stack_mem[sp_ff[IDX_W-1:0]] <= acc_ff;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_sp_bound: assert property (@(posedge clock) disable iff (reset)
      sp_ff <= SP_W'(STACK_DEPTH))
      else $error("stack pointer beyond depth");

   a_stop_sticky: assert property (@(posedge clock) disable iff (reset)
      stopped_ff |=> stopped_ff)
      else $error("stopped state cleared without reset");

   a_sid_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.status != acb_pkg::ST_SYSCALL
      |-> rsp_data_ff.syscall_id == 8'd0)
      else $error("syscall id set on non-syscall response");

   a_stopped_hold: assert property (@(posedge clock) disable iff (reset)
      stopped_ff && exec_go |=> $stable(pc_ff) && $stable(acc_ff) && $stable(sp_ff))
      else $error("state changed while stopped");

   a_pop_push_excl: assert property (@(posedge clock) disable iff (reset)
      !(do_push && do_pop))
      else $error("push and pop in one instruction");

endmodule

[dv/tb_accumulator_bytecode_cpu_unit.sv]
// Self-checking testbench for the accumulator bytecode CPU unit.
`timescale 1ns / 1ps

module tb_accumulator_bytecode_cpu_unit;

   localparam int unsigned CYCLE_LIMIT  = 200000;
   localparam int unsigned DRAIN_CYCLES = 10;
   localparam int unsigned MAX_REPORTS  = 10;
   localparam int unsigned RANDOM_ITEMS = 330;
   localparam logic [7:0]  OP_ZERO_BAD  = 8'h00;
   localparam int          SIDX_W       = $clog2(acb_pkg::STACK_DEPTH_DEF);

   logic             clock     = 1'b0;
   logic             reset     = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   acb_pkg::req_type req_data  = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   acb_pkg::rsp_type rsp_data;

   int unsigned send_idle_pct  = 0;
   int unsigned recv_stall_pct = 0;
   int unsigned error_count    = 0;
   int unsigned cycle_count    = 0;

   acb_pkg::rsp_type expected_results[$];

   // shadow copy of the machine state
   logic [7:0]  cpu_pc;
   logic [7:0]  cpu_acc;
   logic        cpu_eq;
   int unsigned cpu_sp;
   logic [7:0]  cpu_stack [acb_pkg::STACK_DEPTH_DEF];
   logic [7:0]  cpu_mem [acb_pkg::MEM_DEPTH];
   logic        cpu_halted;

   accumulator_bytecode_cpu_unit u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAILED: results differ");
         $finish;
      end
   end

   task automatic note_failure(input string msg);
      if (error_count < MAX_REPORTS) $display("ERROR @%0t: %s", $realtime, msg);
      error_count++;
   endtask

   function automatic acb_pkg::rsp_type execute_instr(input acb_pkg::req_type r);
      acb_pkg::rsp_type res;
      logic [7:0]       npc;
      res = '0;
      if (cpu_halted) begin
         res.next_pc   = cpu_pc;
         res.acc_value = cpu_acc;
         res.status    = acb_pkg::ST_STOPPED;
         return res;
      end
      npc        = cpu_pc + 8'd2;
      res.status = acb_pkg::ST_NORMAL;
      case (r.opcode)
         acb_pkg::OP_LOAD_IMM: cpu_acc = r.operand;
         acb_pkg::OP_ADD:      cpu_acc = cpu_acc + r.operand;
         acb_pkg::OP_PRINT: begin
            npc        = cpu_pc + 8'd1;
            res.status = acb_pkg::ST_PRINT;
         end
         acb_pkg::OP_CMP:      cpu_eq = (cpu_acc == r.operand);
         acb_pkg::OP_JEQ:      if (cpu_eq) npc = r.operand;
         acb_pkg::OP_JMP:      npc = r.operand;
         acb_pkg::OP_PUSH: begin
            npc = cpu_pc + 8'd1;
            if (cpu_sp < acb_pkg::STACK_DEPTH_DEF) begin
               cpu_stack[cpu_sp[SIDX_W-1:0]] = cpu_acc;
               cpu_sp++;
            end
         end
         acb_pkg::OP_POP: begin
            npc = cpu_pc + 8'd1;
            if (cpu_sp > 0) begin
               cpu_sp--;
               cpu_acc = cpu_stack[cpu_sp[SIDX_W-1:0]];
            end
         end
         acb_pkg::OP_XOR:      cpu_acc = cpu_acc ^ r.operand;
         acb_pkg::OP_STORE:    cpu_mem[r.operand] = cpu_acc;
         acb_pkg::OP_LOAD:     cpu_acc = cpu_mem[r.operand];
         acb_pkg::OP_SYSCALL: begin
            res.status     = acb_pkg::ST_SYSCALL;
            res.syscall_id = r.operand;
         end
         acb_pkg::OP_HALT: begin
            npc        = cpu_pc + 8'd1;
            res.status = acb_pkg::ST_HALT;
            cpu_halted = 1'b1;
         end
         default: begin
            npc        = cpu_pc + 8'd1;
            res.status = acb_pkg::ST_INVALID;
            cpu_halted = 1'b1;
         end
      endcase
      cpu_pc        = npc;
      res.next_pc   = npc;
      res.acc_value = cpu_acc;
      return res;
   endfunction

   // valid is left high on return; the idle loop of the next call or the end of the test lowers it
   task automatic send_instr(input logic [7:0] op, input logic [7:0] arg);
      acb_pkg::req_type item;
      item.opcode  = op;
      item.operand = arg;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      expected_results.push_back(execute_instr(item));
   endtask

   always @(posedge clock) begin : check_results
      acb_pkg::rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               note_failure($sformatf("unexpected result %h", rsp_data));
            end else begin
               want = expected_results.pop_front();
               if (rsp_data.next_pc !== want.next_pc ||
                   rsp_data.acc_value !== want.acc_value ||
                   rsp_data.status !== want.status ||
                   rsp_data.syscall_id !== want.syscall_id) begin
                  note_failure($sformatf(
                     "exp pc=%h acc=%h st=%0d id=%h got pc=%h acc=%h st=%0d id=%h",
                     want.next_pc, want.acc_value, want.status, want.syscall_id,
                     rsp_data.next_pc, rsp_data.acc_value, rsp_data.status,
                     rsp_data.syscall_id));
               end
            end
         end
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   task automatic test_each_opcode();
      send_instr(acb_pkg::OP_LOAD_IMM, 8'h00);
      send_instr(acb_pkg::OP_LOAD_IMM, 8'hFF);
      send_instr(acb_pkg::OP_ADD, 8'h01);       // wraps to zero
      send_instr(acb_pkg::OP_ADD, 8'hFF);
      send_instr(acb_pkg::OP_XOR, 8'hFF);
      send_instr(acb_pkg::OP_XOR, 8'hA5);
      send_instr(acb_pkg::OP_PRINT, 8'h77);
      send_instr(acb_pkg::OP_CMP, 8'hA5);
      send_instr(acb_pkg::OP_JEQ, 8'h40);       // taken
      send_instr(acb_pkg::OP_CMP, 8'h00);
      send_instr(acb_pkg::OP_JEQ, 8'h80);       // not taken
      send_instr(acb_pkg::OP_JMP, 8'hFF);
      send_instr(acb_pkg::OP_PRINT, 8'h00);     // pc wraps past 0xFF
      send_instr(acb_pkg::OP_JMP, 8'hFE);
      send_instr(acb_pkg::OP_ADD, 8'h00);
      send_instr(acb_pkg::OP_STORE, 8'h00);
      send_instr(acb_pkg::OP_LOAD_IMM, 8'h3C);
      send_instr(acb_pkg::OP_STORE, 8'hFF);
      send_instr(acb_pkg::OP_LOAD, 8'h80);      // never written, reads zero
      send_instr(acb_pkg::OP_LOAD, 8'h00);
      send_instr(acb_pkg::OP_LOAD, 8'hFF);
      send_instr(acb_pkg::OP_SYSCALL, 8'h00);
      send_instr(acb_pkg::OP_SYSCALL, 8'hFF);
      send_instr(acb_pkg::OP_SYSCALL, 8'h5A);
      send_instr(acb_pkg::OP_PUSH, 8'hFF);
      send_instr(acb_pkg::OP_POP, 8'h00);
   endtask

   task automatic test_stack_limits();
      int i;
      // drain, then one extra pop on the empty stack
      while (cpu_sp > 0) send_instr(acb_pkg::OP_POP, 8'($urandom));
      send_instr(acb_pkg::OP_POP, 8'($urandom));
      for (i = 0; i < acb_pkg::STACK_DEPTH_DEF + 2; i++) begin
         send_instr(acb_pkg::OP_LOAD_IMM, 8'(i * 7 + 3));
         send_instr(acb_pkg::OP_PUSH, 8'($urandom));
      end
      for (i = 0; i < acb_pkg::STACK_DEPTH_DEF + 2; i++)
         send_instr(acb_pkg::OP_POP, 8'($urandom));
   endtask

   task automatic test_random_program(input int unsigned n_items);
      int unsigned sent;
      int unsigned burst;
      int unsigned j;
      logic [7:0]  op;
      logic [7:0]  arg;
      sent = 0;
      while (sent < n_items) begin
         case ($urandom_range(9))
            0: begin
               burst = $urandom_range(40, 1);
               for (j = 0; j < burst; j++) begin
                  if ($urandom_range(1)) begin
                     send_instr(acb_pkg::OP_LOAD_IMM, 8'($urandom));
                     sent++;
                  end
                  send_instr(acb_pkg::OP_PUSH, 8'($urandom));
                  sent++;
               end
            end
            1: begin
               burst = $urandom_range(40, 1);
               for (j = 0; j < burst; j++) send_instr(acb_pkg::OP_POP, 8'($urandom));
               sent += burst;
            end
            default: begin
               op  = 8'($urandom_range(acb_pkg::OP_SYSCALL, acb_pkg::OP_LOAD_IMM));
               arg = 8'($urandom);
               case ($urandom_range(3))
                  0: arg = 8'h00;
                  1: arg = 8'hFF;
                  default: ;
               endcase
               if (op == acb_pkg::OP_CMP && $urandom_range(1)) arg = cpu_acc;
               if ((op == acb_pkg::OP_STORE || op == acb_pkg::OP_LOAD) &&
                   $urandom_range(1))
                  arg = 8'($urandom_range(15));
               send_instr(op, arg);
               sent++;
            end
         endcase
      end
   endtask

   // only one stop per run since reset is never reapplied
   task automatic test_stop_state();
      logic [7:0] bad_op;
      int         i;
      if ($urandom_range(1)) begin
         send_instr(acb_pkg::OP_HALT, 8'($urandom));
      end else begin
         bad_op = 8'($urandom_range(acb_pkg::OP_HALT - 8'd1, acb_pkg::OP_SYSCALL + 8'd1));
         if ($urandom_range(3) == 0) bad_op = OP_ZERO_BAD;
         send_instr(bad_op, 8'($urandom));
      end
      for (i = 0; i < 24; i++) send_instr(8'($urandom), 8'($urandom));
      send_instr(acb_pkg::OP_HALT, 8'hFF);
      send_instr(acb_pkg::OP_LOAD_IMM, 8'h00);
   endtask

   initial begin
      cpu_pc     = '0;
      cpu_acc    = '0;
      cpu_eq     = 1'b0;
      cpu_sp     = 0;
      cpu_halted = 1'b0;
      foreach (cpu_stack[i]) cpu_stack[i] = '0;
      foreach (cpu_mem[i]) cpu_mem[i] = '0;

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_idle_pct  = 26;
      recv_stall_pct = 68;
      test_each_opcode();
      test_stack_limits();
      test_random_program(RANDOM_ITEMS);

      send_idle_pct  = 68;
      recv_stall_pct = 26;
      test_random_program(RANDOM_ITEMS);

      send_idle_pct  = 0;
      recv_stall_pct = 0;
      test_random_program(RANDOM_ITEMS);
      test_stop_state();

      req_valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

[accumulator_bytecode_cpu_unit.f]
src/acb_pkg.sv
src/accumulator_bytecode_cpu_unit.sv
dv/tb_accumulator_bytecode_cpu_unit.sv
